/* design/g7enc_pkg.sv */
// Shared types, constants and the microcode store of the group-of-seven encoder.
`default_nettype none
package g7enc_pkg;

    typedef struct packed {
        logic       func;
        logic [6:0] source_id;
        logic [7:0] packet_type;
        logic [6:0] status_code;
        logic [9:0] packet_length;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       packet_end;
    } out_word_t;

    localparam logic       FUNC_START = 1'b0;
    localparam logic [9:0] MAX_LEN    = 10'd895;
    localparam int         GROUP      = 7;
    localparam logic [2:0] GROUP_CNT  = 3'(GROUP);
    localparam logic [23:0] RECIP7_MUL = 24'd9363;   // 2^16 / 7, rounded up

    // byte source select
    localparam logic [3:0] SEL_CONST = 4'd0;
    localparam logic [3:0] SEL_SRC   = 4'd1;
    localparam logic [3:0] SEL_TYPE  = 4'd2;
    localparam logic [3:0] SEL_STAT  = 4'd3;
    localparam logic [3:0] SEL_ODDS  = 4'd4;
    localparam logic [3:0] SEL_GRPS  = 4'd5;
    localparam logic [3:0] SEL_MSB   = 4'd6;
    localparam logic [3:0] SEL_HOLD  = 4'd7;
    localparam logic [3:0] SEL_CHKA  = 4'd8;
    localparam logic [3:0] SEL_CHKB  = 4'd9;

    // branch kinds
    localparam logic [1:0] BR_NEXT  = 2'd0;
    localparam logic [1:0] BR_TRAIL = 2'd1;   // to trailer if pending, else stop
    localparam logic [1:0] BR_LOOP  = 2'd2;   // repeat over held bytes, then as BR_TRAIL
    localparam logic [1:0] BR_END   = 2'd3;

    // program entry points
    localparam logic [4:0] PC_START = 5'd0;
    localparam logic [4:0] PC_FLUSH = 5'd14;
    localparam logic [4:0] PC_TRAIL = 5'd16;

    typedef struct packed {
        logic [3:0] sel;
        logic [7:0] konst;
        logic [1:0] br;
        logic [4:0] target;
        logic       chk_en;
        logic       cap_odds;
        logic       is_end;
    } ctl_t;

    typedef struct packed {
        logic       launch;
        logic [4:0] entry;
        logic       trail;
        logic [2:0] cnt;
        logic       fire;
    } seq_cmd_t;

    typedef struct packed {
        logic       busy;
        logic       last;
        logic [2:0] idx;
        ctl_t       ctl;
    } seq_stat_t;

    function automatic ctl_t mk_ctl(input logic [3:0] sel, input logic [7:0] konst,
                                    input logic [1:0] br, input logic chk_en,
                                    input logic cap_odds, input logic is_end);
        ctl_t c;
        c.sel      = sel;
        c.konst    = konst;
        c.br       = br;
        c.target   = PC_TRAIL;
        c.chk_en   = chk_en;
        c.cap_odds = cap_odds;
        c.is_end   = is_end;
        return c;
    endfunction

    function automatic ctl_t rom_read(input logic [4:0] pc);
        ctl_t c;
        case (pc)
            5'd0:    c = mk_ctl(SEL_CONST, 8'hFF, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd1:    c = mk_ctl(SEL_CONST, 8'h3F, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd2:    c = mk_ctl(SEL_CONST, 8'hCF, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd3:    c = mk_ctl(SEL_CONST, 8'hF3, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd4:    c = mk_ctl(SEL_CONST, 8'hFC, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd5:    c = mk_ctl(SEL_CONST, 8'hFF, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd6:    c = mk_ctl(SEL_CONST, 8'hC3, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd7:    c = mk_ctl(SEL_CONST, 8'h80, BR_NEXT,  1'b1, 1'b0, 1'b0);
            5'd8:    c = mk_ctl(SEL_SRC,   8'h00, BR_NEXT,  1'b1, 1'b0, 1'b0);
            5'd9:    c = mk_ctl(SEL_TYPE,  8'h00, BR_NEXT,  1'b1, 1'b0, 1'b0);
            5'd10:   c = mk_ctl(SEL_CONST, 8'h80, BR_NEXT,  1'b1, 1'b0, 1'b0);
            5'd11:   c = mk_ctl(SEL_STAT,  8'h00, BR_NEXT,  1'b1, 1'b0, 1'b0);
            5'd12:   c = mk_ctl(SEL_ODDS,  8'h00, BR_NEXT,  1'b1, 1'b1, 1'b0);
            5'd13:   c = mk_ctl(SEL_GRPS,  8'h00, BR_TRAIL, 1'b1, 1'b0, 1'b0);
            5'd14:   c = mk_ctl(SEL_MSB,   8'h00, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd15:   c = mk_ctl(SEL_HOLD,  8'h00, BR_LOOP,  1'b0, 1'b0, 1'b0);
            5'd16:   c = mk_ctl(SEL_CHKA,  8'h00, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd17:   c = mk_ctl(SEL_CHKB,  8'h00, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd18:   c = mk_ctl(SEL_CONST, 8'hC8, BR_NEXT,  1'b0, 1'b0, 1'b0);
            5'd19:   c = mk_ctl(SEL_CONST, 8'h00, BR_END,   1'b0, 1'b0, 1'b1);
            default: c = mk_ctl(SEL_CONST, 8'h00, BR_END,   1'b0, 1'b0, 1'b0);
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* design/g7enc_seq.sv */
// Microcode sequencer: step counter, loop index and control store.
`default_nettype none
module g7enc_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire g7enc_pkg::seq_cmd_t cmd,
    output g7enc_pkg::seq_stat_t     stat
);
    import g7enc_pkg::*;

    logic [4:0] pc_reg, pc_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       trail_reg, trail_next;
    ctl_t       ctl;
    logic       loop_done;
    logic       last;

    assign ctl       = rom_read(pc_reg);
    assign loop_done = (idx_reg == cnt_reg - 3'd1);

    always_comb
    begin
        case (ctl.br)
            BR_NEXT:  last = 1'b0;
            BR_TRAIL: last = !trail_reg;
            BR_LOOP:  last = loop_done && !trail_reg;
            default:  last = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        trail_next = trail_reg;
        if (cmd.launch) begin
            pc_next    = cmd.entry;
            idx_next   = 3'd0;
            cnt_next   = cmd.cnt;
            busy_next  = 1'b1;
            trail_next = cmd.trail;
        end else if (cmd.fire) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                case (ctl.br)
                    BR_NEXT:  pc_next = pc_reg + 5'd1;
                    BR_LOOP:
                    begin
                        if (loop_done)
                            pc_next = ctl.target;
                        else
                            idx_next = idx_reg + 3'd1;
                    end
                    default:  pc_next = ctl.target;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg    <= PC_START;
            idx_reg   <= 3'd0;
            cnt_reg   <= 3'd0;
            busy_reg  <= 1'b0;
            trail_reg <= 1'b0;
        end else begin
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            trail_reg <= trail_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.last = last;
    assign stat.idx  = idx_reg;
    assign stat.ctl  = ctl;

endmodule
`default_nettype wire

/* design/group_of_seven_packet_encoder_top.sv */
// Top level of the group-of-seven packet encoder: datapath and word channels.
`default_nettype none
// Usage: a start word (func 0) opens a packet and yields 14 output bytes (sync
// and header), or 18 when the length is zero, since the trailer follows at
// once. Each data word (func 1) is buffered; a word that completes the odd
// section or a group of seven yields cnt+1 bytes (top-bit byte plus the held
// bytes), and the last data word of the packet adds the 4-byte trailer. Other
// data words, and data words with no packet open, yield nothing. Output runs at
// one byte per clock while enc_ready is high: a microcoded sequencer steps
// through a 20-entry control store, one step per byte, and the input is blocked
// while that program runs. A one-word output register decouples the channels;
// the next item is taken while the last byte still waits. Lengths above 895 are
// clamped; a start word during an open packet drops it with no trailer.
module group_of_seven_packet_encoder_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output      logic                 item_ready,
    input  wire g7enc_pkg::in_word_t  item_word,
    output      logic                 enc_valid,
    input  wire logic                 enc_ready,
    output      g7enc_pkg::out_word_t enc_word
);
    import g7enc_pkg::*;

    seq_cmd_t  cmd;
    seq_stat_t stat;

    logic       accept;
    logic       fire;
    logic [9:0] len_clamp;

    // packet state
    logic       active_reg, active_next;
    logic [9:0] rem_reg, rem_next;
    logic [2:0] fill_reg, fill_next;
    logic       in_odd_reg, in_odd_next;
    logic [7:0] chk_reg, chk_next;
    logic [7:0] hold_reg [GROUP];

    // header fields held for the program
    logic [6:0] src_reg;
    logic [7:0] type_reg;
    logic [6:0] stat_reg;
    logic [9:0] len_reg;

    // len / 7 and len % 7 by reciprocal; grps_reg is registered from len_reg, odds_reg from both
    logic [23:0] prod;
    logic [6:0]  grps_reg;
    logic [9:0]  grps_x7;
    logic [9:0]  rem7;
    logic [2:0]  odds_reg;

    logic [2:0] fill_inc;
    logic [2:0] size;
    logic [9:0] rem_dec;
    logic       flush;
    logic [7:0] msb_byte;
    logic [7:0] out_byte;

    // count of bytes in the section being emitted
    logic [2:0] held_cnt_reg;

    logic      enc_valid_reg;
    out_word_t enc_word_reg;

    assign item_ready = !stat.busy;
    assign accept     = item_valid && item_ready;
    assign fire       = stat.busy && (!enc_valid_reg || enc_ready);
    assign len_clamp  = (item_word.packet_length > MAX_LEN) ? MAX_LEN
                                                             : item_word.packet_length;

    assign prod    = 24'(len_reg) * RECIP7_MUL;
    assign grps_x7 = {grps_reg, 3'b000} - 10'(grps_reg);
    assign rem7    = len_reg - grps_x7;

    always_ff @(posedge clk)
    begin
        grps_reg <= prod[22:16];
        odds_reg <= rem7[2:0];
    end

    // data-word bookkeeping
    assign fill_inc = fill_reg + 3'd1;
    assign size     = in_odd_reg ? odds_reg : GROUP_CNT;
    assign rem_dec  = rem_reg - 10'd1;
    assign flush    = (fill_inc >= size) || (rem_dec == 10'd0);

    always_comb
    begin
        cmd.launch  = 1'b0;
        cmd.entry   = PC_START;
        cmd.trail   = 1'b0;
        cmd.cnt     = 3'd0;
        cmd.fire    = fire;
        active_next = active_reg;
        rem_next    = rem_reg;
        fill_next   = fill_reg;
        in_odd_next = in_odd_reg;
        chk_next    = chk_reg;
        if (accept) begin
            if (item_word.func == FUNC_START) begin
                cmd.launch  = 1'b1;
                cmd.entry   = PC_START;
                cmd.trail   = (len_clamp == 10'd0);
                active_next = (len_clamp != 10'd0);
                rem_next    = len_clamp;
                fill_next   = 3'd0;
                in_odd_next = 1'b0;
                chk_next    = 8'h00;
            end else if (active_reg) begin
                chk_next  = chk_reg ^ item_word.data_byte;
                rem_next  = rem_dec;
                fill_next = fill_inc;
                if (flush) begin
                    cmd.launch  = 1'b1;
                    cmd.entry   = PC_FLUSH;
                    cmd.trail   = (rem_dec == 10'd0);
                    cmd.cnt     = fill_inc;
                    fill_next   = 3'd0;
                    in_odd_next = 1'b0;
                    active_next = (rem_dec != 10'd0);
                end
            end
        end else if (fire) begin
            if (stat.ctl.chk_en)
                chk_next = chk_reg ^ out_byte;
            // odd section length is known once the header goes out
            if (stat.ctl.cap_odds)
                in_odd_next = (odds_reg != 3'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            rem_reg    <= 10'd0;
            fill_reg   <= 3'd0;
            in_odd_reg <= 1'b0;
            chk_reg    <= 8'h00;
        end else begin
            active_reg <= active_next;
            rem_reg    <= rem_next;
            fill_reg   <= fill_next;
            in_odd_reg <= in_odd_next;
            chk_reg    <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item_word.func == FUNC_START) begin
            src_reg  <= item_word.source_id;
            type_reg <= item_word.packet_type;
            stat_reg <= item_word.status_code;
            len_reg  <= len_clamp;
        end
        if (accept && item_word.func != FUNC_START && active_reg)
            hold_reg[fill_reg] <= item_word.data_byte;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.launch)
            held_cnt_reg <= cmd.cnt;
    end

    // top-bit byte: held byte i gives bit 6-i
    always_comb
    begin
        msb_byte = 8'h80;
        for (int i = 0; i < GROUP; i++) begin
            if (3'(i) < held_cnt_reg)
                msb_byte[6 - i] = hold_reg[i][7];
        end
    end

    always_comb
    begin
        case (stat.ctl.sel)
            SEL_CONST: out_byte = stat.ctl.konst;
            SEL_SRC:   out_byte = {1'b1, src_reg};
            SEL_TYPE:  out_byte = type_reg;
            SEL_STAT:  out_byte = {1'b1, stat_reg};
            SEL_ODDS:  out_byte = {5'b10000, odds_reg};
            SEL_GRPS:  out_byte = {1'b1, grps_reg};
            SEL_MSB:   out_byte = msb_byte;
            SEL_HOLD:  out_byte = hold_reg[stat.idx] | 8'h80;
            SEL_CHKA:  out_byte = chk_reg | 8'hAA;
            SEL_CHKB:  out_byte = {1'b0, chk_reg[7:1]} | 8'hAA;
            default:   out_byte = 8'h00;
        endcase
    end

    g7enc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enc_valid_reg <= 1'b0;
        else if (fire)
            enc_valid_reg <= 1'b1;
        else if (enc_ready)
            enc_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            enc_word_reg.out_byte   <= out_byte;
            enc_word_reg.run_last   <= stat.last;
            enc_word_reg.packet_end <= stat.ctl.is_end;
        end
    end

    assign enc_valid = enc_valid_reg;
    assign enc_word  = enc_word_reg;

endmodule
`default_nettype wire

/* verif/g7enc_wire_checker.sv */
`timescale 1ns / 100ps
// Checker for the group-of-seven encoder: predicts the wire bytes of each word and compares.
module g7enc_wire_checker
    import g7enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_ready,
    input  in_word_t  item_word,
    input  logic      enc_valid,
    input  logic      enc_ready,
    input  out_word_t enc_word,
    output int        outstanding,
    output int        fail_count
);

    localparam logic [47:0] SYNC_BYTES = 48'hFF_3F_CF_F3_FC_FF;
    localparam int          MAX_PRINTS = 20;

    // expected wire bytes, oldest first
    out_word_t  wire_q[$];
    out_word_t  want;

    // shadow of the encoder's packet state
    logic       pkt_open;
    int         bytes_left;
    int         odd_len;
    logic       in_odd;
    int         fill;
    logic [7:0] hold [GROUP];
    logic [7:0] chksum;

    int         mistakes = 0;
    int         byte_no  = 0;

    task automatic report_mismatch(input string msg);
        if (mistakes < MAX_PRINTS)
            $display("%0t ns: wire byte %0d: %s", $time, byte_no, msg);
        mistakes++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic is_end);
        out_word_t o;
        o.out_byte   = b;
        o.run_last   = 1'b0;
        o.packet_end = is_end;
        wire_q.push_back(o);
    endtask

    // header bytes from dest through group count feed the checksum
    task automatic push_hdr(input logic [7:0] b);
        push_byte(b, 1'b0);
        chksum ^= b;
    endtask

    task automatic push_trailer();
        push_byte(chksum | 8'hAA, 1'b0);
        push_byte((chksum >> 1) | 8'hAA, 1'b0);
        push_byte(8'hC8, 1'b0);
        push_byte(8'h00, 1'b1);
    endtask

    task automatic predict_words(input in_word_t w);
        int         first;
        int         len;
        int         size;
        int         cnt;
        logic [7:0] top_bits;
        out_word_t  tail;
        first = wire_q.size();
        if (w.func == FUNC_START) begin
            len = (w.packet_length > MAX_LEN) ? int'(MAX_LEN) : int'(w.packet_length);
            for (int i = 5; i >= 0; i--)
                push_byte(SYNC_BYTES[i*8 +: 8], 1'b0);
            push_byte(8'hC3, 1'b0);
            chksum = 8'h00;
            push_hdr(8'h80);
            push_hdr({1'b1, w.source_id});
            push_hdr(w.packet_type);
            push_hdr(8'h80);
            push_hdr({1'b1, w.status_code});
            push_hdr(8'h80 | 8'(len % GROUP));
            push_hdr(8'h80 | 8'(len / GROUP));
            bytes_left = len;
            odd_len    = len % GROUP;
            in_odd     = (odd_len > 0);
            fill       = 0;
            pkt_open   = (len > 0);
            if (!pkt_open)
                push_trailer();
        end else if (pkt_open) begin
            size = in_odd ? odd_len : GROUP;
            if (fill < GROUP)
                hold[fill] = w.data_byte;
            fill++;
            chksum ^= w.data_byte;
            if (bytes_left > 0)
                bytes_left--;
            if (fill >= size || bytes_left == 0) begin
                cnt      = (fill > GROUP) ? GROUP : fill;
                // bit 7 always set, byte i gives bit 6-i
                top_bits = 8'h80;
                for (int i = 0; i < cnt; i++)
                    top_bits |= (hold[i] & 8'h80) >> (1 + i);
                push_byte(top_bits, 1'b0);
                for (int i = 0; i < cnt; i++)
                    push_byte(hold[i] | 8'h80, 1'b0);
                fill   = 0;
                in_odd = 1'b0;
            end
            if (bytes_left == 0) begin
                push_trailer();
                pkt_open = 1'b0;
            end
        end
        if (wire_q.size() > first) begin
            tail          = wire_q[wire_q.size() - 1];
            tail.run_last = 1'b1;
            wire_q[wire_q.size() - 1] = tail;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_open    = 1'b0;
            bytes_left  = 0;
            odd_len     = 0;
            in_odd      = 1'b0;
            fill        = 0;
            chksum      = 8'h00;
            wire_q.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                predict_words(item_word);
            if (enc_valid && enc_ready)
            begin
                if (wire_q.size() == 0)
                    report_mismatch($sformatf("unexpected word, byte %02h", enc_word.out_byte));
                else
                begin
                    want = wire_q.pop_front();
                    if (enc_word.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  enc_word.out_byte, want.out_byte));
                    if (enc_word.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  enc_word.run_last, want.run_last));
                    if (enc_word.packet_end !== want.packet_end)
                        report_mismatch($sformatf("packet_end %b, expected %b",
                                                  enc_word.packet_end, want.packet_end));
                end
                byte_no++;
            end
            outstanding <= wire_q.size();
            fail_count  <= mistakes;
        end
    end

endmodule

/* verif/tb_group_of_seven_packet_encoder_top.sv */
`timescale 1ns / 100ps
// Testbench top for the group-of-seven packet encoder: stimulus, flow control and verdict.
module tb_group_of_seven_packet_encoder_top;
    import g7enc_pkg::*;

    // data words carry the other function code
    localparam logic FUNC_DATA  = ~FUNC_START;
    localparam int   DRAIN_WAIT = 40;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_word_t  item_word;
    logic      enc_valid;
    logic      enc_ready = 1'b0;
    out_word_t enc_word;

    int        outstanding;
    int        fail_count;

    // flow-control knobs, percent of cycles spent idle / stalled
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    group_of_seven_packet_encoder_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_word  (item_word),
        .enc_valid  (enc_valid),
        .enc_ready  (enc_ready),
        .enc_word   (enc_word)
    );

    // The checker sees both channels, keeps the expected bytes and reports
    // back how many are still owed and how many mismatches it found.
    g7enc_wire_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_word   (item_word),
        .enc_valid   (enc_valid),
        .enc_ready   (enc_ready),
        .enc_word    (enc_word),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always #10 clk = ~clk;

    // Receiver: a fresh ready decision every cycle, so stalls land on
    // header, group and trailer bytes alike.
    always @(posedge clk)
        enc_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Hard stop in case the encoder hangs or never drains.
    initial
    begin
        #4_000_000;
        $display("** group_of_seven_packet_encoder_top: FAILED **");
        $finish;
    end

    // One word on the input channel. Valid is left high after acceptance so
    // that a back-to-back word just swaps the payload in the same step; an
    // idle gap lowers it first.
    task automatic send_word(input in_word_t w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        item_word  <= w;
        do @(posedge clk); while (!item_ready);
    endtask

    // Unused fields get random junk; the encoder must not look at them.
    task automatic send_start(input logic [9:0] len, input logic [6:0] src,
                              input logic [7:0] typ, input logic [6:0] st);
        logic [63:0] junk;
        in_word_t    w;
        junk            = {$urandom, $urandom};
        w               = junk[$bits(in_word_t)-1:0];
        w.func          = FUNC_START;
        w.source_id     = src;
        w.packet_type   = typ;
        w.status_code   = st;
        w.packet_length = len;
        send_word(w);
    endtask

    task automatic send_data(input logic [7:0] d);
        logic [63:0] junk;
        in_word_t    w;
        junk        = {$urandom, $urandom};
        w           = junk[$bits(in_word_t)-1:0];
        w.func      = FUNC_DATA;
        w.data_byte = d;
        send_word(w);
    endtask

    // Stop sending and wait until every expected byte has left the encoder.
    // The count from the checker is registered, so look after an edge.
    task automatic drain_output();
        item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Mostly complete packets with random header and payload; a few are cut
    // short (the next start word abandons them), a few ask for more than the
    // clamp allows, and stray data bytes fall between packets.
    task automatic random_packets(input int n_words);
        int         sent;
        int         len;
        int         keep;
        int         pick;
        logic [9:0] len_field;
        sent = 0;
        while (sent < n_words)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_data(8'($urandom_range(255)));
            else
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    len = 0;
                else if (pick < 75)
                    len = $urandom_range(20, 1);
                else
                    len = $urandom_range(50, 21);
                len_field = 10'(len);
                keep      = len;
                if ($urandom_range(99) < 8)
                begin
                    // oversize length, clamped, then abandoned early
                    len_field = 10'($urandom_range(1023, 896));
                    keep      = $urandom_range(12);
                end
                else if (len > 0 && $urandom_range(99) < 10)
                    keep = $urandom_range(len - 1);
                send_start(len_field, 7'($urandom_range(127)), 8'($urandom_range(255)),
                           7'($urandom_range(127)));
                repeat (keep)
                    send_data(8'($urandom_range(255)));
                sent += 1 + keep;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid <= 1'b0;
        item_word  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed words, no idling ----
        // empty packets: header plus trailer at once, all-zero and all-one fields
        send_start(10'd0, 7'd0, 8'h00, 7'd0);
        send_start(10'd0, 7'd127, 8'hFF, 7'd127);
        // stray byte with no packet open is dropped
        send_data(8'hFF);
        // one-byte odd section only
        send_start(10'd1, 7'd5, 8'h80, 7'd1);
        send_data(8'hFF);
        // exactly one group of seven, no odd section
        send_start(10'd7, 7'd64, 8'h01, 7'd64);
        send_data(8'h80);
        send_data(8'h7F);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h55);
        send_data(8'hAA);
        send_data(8'h01);
        // hold the sender off until everything is out
        drain_output();
        // oversize length gets clamped; the packet is left open mid odd section
        send_start(10'd1023, 7'd33, 8'h5A, 7'd99);
        send_data(8'hC3);
        send_data(8'h3C);
        // restart while open: odd byte then a full group
        send_start(10'd8, 7'd126, 8'hA5, 7'd42);
        send_data(8'h00);
        repeat (7)
            send_data(8'($urandom_range(255)));

        // ---- random, no idling ----
        random_packets(12);

        // ---- sender mostly idle ----
        drain_output();
        send_idle_pct = 88;
        random_packets(12);

        // ---- receiver mostly stalled ----
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        random_packets(12);

        // ---- light idling on both sides ----
        drain_output();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        random_packets(12);

        // wait for the last bytes, then keep the clock running to catch anything extra
        drain_output();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("** group_of_seven_packet_encoder_top: PASSED **");
        else
            $display("** group_of_seven_packet_encoder_top: FAILED **");
        $finish;
    end

endmodule
